FILE: rtl/bst_pkg.sv
// Package for the Bezier scoop trajectory core.
// Holds field widths, the configuration record and the sequencer states.
// No dependencies.
package bst_pkg;

	localparam int COORD_W   = 24;
	localparam int MAX_STEPS = 63;
	localparam int STEP_W    = 6;
	localparam int TOOL_W    = 14;
	localparam int GEOM_W    = 16;
	localparam int TPOS_W    = 12;
	localparam int RATIO_W   = 17;
	localparam int MUL_A_W   = 33;
	localparam int MUL_B_W   = 18;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int APB_AW    = 5;
	localparam int APB_DW    = 32;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_STEP_COUNT  = 3'd0;
	localparam logic [2:0] REG_TOOL_SCOOP  = 3'd1;
	localparam logic [2:0] REG_TOOL_CENTER = 3'd2;
	localparam logic [2:0] REG_CURVE_DEPTH = 3'd3;
	localparam logic [2:0] REG_CURVE_REACH = 3'd4;

	typedef struct packed {
		logic [STEP_W-1:0]        step_count;
		logic signed [TOOL_W-1:0] tool_scoop_pos;
		logic signed [TOOL_W-1:0] tool_center_pos;
		logic [GEOM_W-1:0]        curve_depth;
		logic [GEOM_W-1:0]        curve_reach;
	} bst_cfg_t;

	typedef enum logic [10:0] {
		ST_IDLE = 11'b00000000001,
		ST_DIV  = 11'b00000000010,
		ST_M1   = 11'b00000000100,
		ST_M2   = 11'b00000001000,
		ST_M3   = 11'b00000010000,
		ST_M4   = 11'b00000100000,
		ST_M5   = 11'b00001000000,
		ST_M6   = 11'b00010000000,
		ST_M7   = 11'b00100000000,
		ST_FIN  = 11'b01000000000,
		ST_EMIT = 11'b10000000000
	} bst_state_t;

endpackage

FILE: rtl/bst_ifs.sv
// Streaming channel interfaces for the Bezier scoop trajectory core.
// Depends on bst_pkg for the field widths.
interface bst_in_if;
	import bst_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] base_x;
	logic signed [COORD_W-1:0] base_y;
	logic signed [COORD_W-1:0] base_z;
	modport source (output valid, base_x, base_y, base_z, input ready);
	modport sink (input valid, base_x, base_y, base_z, output ready);
endinterface

interface bst_out_if;
	import bst_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic signed [COORD_W-1:0] point_z;
	logic                      tool_valid;
	logic [TPOS_W-1:0]         tool_pos;
	logic                      last_point;
	modport source (output valid, point_x, point_y, point_z, tool_valid, tool_pos,
		last_point, input ready);
	modport sink (input valid, point_x, point_y, point_z, tool_valid, tool_pos,
		last_point, output ready);
endinterface

FILE: rtl/bst_regs.sv
// Configuration register bank with an APB-style write and read port.
// Depends on bst_pkg for the register record and indexes.
module bst_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bst_pkg::APB_AW-1:0] paddr,
	input  logic [bst_pkg::APB_DW-1:0] pwdata,
	output logic [bst_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output bst_pkg::bst_cfg_t          cfg
);
	import bst_pkg::*;

	bst_cfg_t   cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[APB_AW-1:2];
	assign cfg    = cfg_q;

	// Register writes at the access phase of a write transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_count      <= STEP_W'(32);
			cfg_q.tool_scoop_pos  <= TOOL_W'(2048);
			cfg_q.tool_center_pos <= TOOL_W'(2048);
			cfg_q.curve_depth     <= GEOM_W'(12800);
			cfg_q.curve_reach     <= GEOM_W'(12800);
		end else if (wr_en) begin
			unique case (idx)
				REG_STEP_COUNT:  cfg_q.step_count      <= pwdata[STEP_W-1:0];
				REG_TOOL_SCOOP:  cfg_q.tool_scoop_pos  <= pwdata[TOOL_W-1:0];
				REG_TOOL_CENTER: cfg_q.tool_center_pos <= pwdata[TOOL_W-1:0];
				REG_CURVE_DEPTH: cfg_q.curve_depth     <= pwdata[GEOM_W-1:0];
				REG_CURVE_REACH: cfg_q.curve_reach     <= pwdata[GEOM_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux; addresses beyond the list read as zero.
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_STEP_COUNT:  prdata[STEP_W-1:0] = cfg_q.step_count;
			REG_TOOL_SCOOP:  prdata[TOOL_W-1:0] = cfg_q.tool_scoop_pos;
			REG_TOOL_CENTER: prdata[TOOL_W-1:0] = cfg_q.tool_center_pos;
			REG_CURVE_DEPTH: prdata[GEOM_W-1:0] = cfg_q.curve_depth;
			REG_CURVE_REACH: prdata[GEOM_W-1:0] = cfg_q.curve_reach;
			default: ;
		endcase
	end

endmodule

FILE: rtl/bst_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on bst_pkg for the operand widths.
module bst_mul (
	input  logic                        clk,
	input  logic [bst_pkg::MUL_A_W-1:0] a,
	input  logic [bst_pkg::MUL_B_W-1:0] b,
	output logic [bst_pkg::MUL_P_W-1:0] p_q
);
	import bst_pkg::*;

	// One product per cycle, read by the sequencer in the following state.
	always_ff @(posedge clk) begin
		p_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

endmodule

FILE: rtl/bst_seq.sv
// Sequencer and datapath: ratio divider, step ratio accumulator and the
// operand schedule of the shared multiplier. Depends on bst_pkg and bst_mul.
module bst_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  bst_pkg::bst_cfg_t cfg,
	bst_in_if.sink            in_ch,
	bst_out_if.source         out_ch
);
	import bst_pkg::*;

	bst_state_t state_q;

	logic signed [COORD_W-1:0] bx_q, by_q, bz_q;
	logic [STEP_W-1:0]  n_q, step_q;
	logic [4:0]         div_cnt_q;
	logic [RATIO_W-1:0] q0_q;
	logic [STEP_W-1:0]  rem0_q;
	logic [RATIO_W-1:0] r_q;
	logic [STEP_W-1:0]  racc_q;
	logic [16:0]        offz_q, offx_q, xhi_q;
	logic [MUL_P_W-1:0] plo_q;

	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] prod;

	logic [STEP_W:0]    div_sh;
	logic               div_bit;
	logic [STEP_W:0]    div_rem;
	logic [STEP_W:0]    acc_sum;
	logic [RATIO_W-1:0] u;
	logic [17:0]        dep3, kx;
	logic [16:0]        rr;
	logic [14:0]        diff, absd;
	logic [67:0]        psum;
	logic [MUL_P_W-1:0] zrnd;
	logic [14:0]        tq;
	logic [15:0]        raw;
	logic [COORD_W:0]   sx, sz;

	bst_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_q(prod));

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign out_ch.valid = (state_q == ST_EMIT);

	// Restoring divider step for 65536 / N, one quotient bit a cycle.
	assign div_sh  = {rem0_q, (div_cnt_q == 5'd16)};
	assign div_bit = (div_sh >= {1'b0, n_q});
	assign div_rem = div_bit ? (div_sh - {1'b0, n_q}) : div_sh;

	// Next ratio: fraction accumulator with carry into the ratio.
	assign acc_sum = {1'b0, racc_q} + {1'b0, rem0_q};

	assign u    = RATIO_W'(65536) - r_q;
	assign dep3 = {1'b0, cfg.curve_depth, 1'b0} + {2'b00, cfg.curve_depth};
	assign kx   = 18'd196608 - {r_q, 1'b0};
	assign rr   = 17'({1'b0, r_q} - 18'd32768) << 1;
	assign diff = {cfg.tool_center_pos[TOOL_W-1], cfg.tool_center_pos}
		- {cfg.tool_scoop_pos[TOOL_W-1], cfg.tool_scoop_pos};
	assign absd = diff[14] ? (15'd0 - diff) : diff;

	// Rounding of the two offsets.
	assign zrnd = prod + MUL_P_W'(64'h8000_0000);
	assign psum = {prod[35:0], 32'd0} + 68'(plo_q) + (68'd1 << 47);

	// Tool ramp, truncated toward zero and clamped.
	assign tq  = prod[30:16];
	assign raw = diff[14]
		? ({{2{cfg.tool_scoop_pos[TOOL_W-1]}}, cfg.tool_scoop_pos} - {1'b0, tq})
		: ({{2{cfg.tool_scoop_pos[TOOL_W-1]}}, cfg.tool_scoop_pos} + {1'b0, tq});

	assign sx = {bx_q[COORD_W-1], bx_q} + (COORD_W+1)'(offx_q);
	assign sz = {bz_q[COORD_W-1], bz_q} - (COORD_W+1)'(offz_q);

	// Operand schedule of the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_M1: begin
				mul_a = MUL_A_W'(u);
				mul_b = MUL_B_W'(r_q);
			end
			ST_M2: begin
				mul_a = MUL_A_W'(prod[30:0]);
				mul_b = dep3;
			end
			ST_M3: begin
				mul_a = MUL_A_W'(cfg.curve_reach);
				mul_b = MUL_B_W'(r_q);
			end
			ST_M4: begin
				mul_a = prod[MUL_A_W-1:0];
				mul_b = MUL_B_W'(r_q);
			end
			ST_M5: begin
				mul_a = MUL_A_W'(prod[31:0]);
				mul_b = kx;
			end
			ST_M6: begin
				mul_a = MUL_A_W'(xhi_q);
				mul_b = kx;
			end
			ST_M7: begin
				mul_a = MUL_A_W'(absd);
				mul_b = MUL_B_W'(rr);
			end
			default: ;
		endcase
	end

	// Sequencer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			n_q       <= '0;
			step_q    <= '0;
			div_cnt_q <= '0;
			q0_q      <= '0;
			rem0_q    <= '0;
			r_q       <= '0;
			racc_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						n_q       <= (cfg.step_count == '0) ? STEP_W'(1) : cfg.step_count;
						div_cnt_q <= 5'd16;
						q0_q      <= '0;
						rem0_q    <= '0;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					q0_q      <= {q0_q[RATIO_W-2:0], div_bit};
					rem0_q    <= div_rem[STEP_W-1:0];
					div_cnt_q <= div_cnt_q - 5'd1;
					if (div_cnt_q == 5'd0) begin
						step_q  <= '0;
						r_q     <= '0;
						racc_q  <= '0;
						state_q <= ST_M1;
					end
				end
				ST_M1:  state_q <= ST_M2;
				ST_M2:  state_q <= ST_M3;
				ST_M3:  state_q <= ST_M4;
				ST_M4:  state_q <= ST_M5;
				ST_M5:  state_q <= ST_M6;
				ST_M6:  state_q <= ST_M7;
				ST_M7:  state_q <= ST_FIN;
				ST_FIN: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_ch.ready) begin
						if (step_q == n_q) begin
							state_q <= ST_IDLE;
						end else begin
							step_q <= step_q + STEP_W'(1);
							if (acc_sum >= {1'b0, n_q}) begin
								racc_q <= STEP_W'(acc_sum - {1'b0, n_q});
								r_q    <= r_q + q0_q + RATIO_W'(1);
							end else begin
								racc_q <= acc_sum[STEP_W-1:0];
								r_q    <= r_q + q0_q;
							end
							state_q <= ST_M1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers: base point, partial products and the result.
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			bx_q <= in_ch.base_x;
			by_q <= in_ch.base_y;
			bz_q <= in_ch.base_z;
		end
		if (state_q == ST_M3) offz_q <= zrnd[48:32];
		if (state_q == ST_M5) xhi_q  <= prod[48:32];
		if (state_q == ST_M6) plo_q  <= prod;
		if (state_q == ST_M7) offx_q <= psum[64:48];
		if (state_q == ST_FIN) begin
			if (sx[COORD_W] != sx[COORD_W-1])
				out_ch.point_x <= sx[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}}
					: {1'b0, {(COORD_W-1){1'b1}}};
			else
				out_ch.point_x <= sx[COORD_W-1:0];
			if (sz[COORD_W] != sz[COORD_W-1])
				out_ch.point_z <= sz[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}}
					: {1'b0, {(COORD_W-1){1'b1}}};
			else
				out_ch.point_z <= sz[COORD_W-1:0];
			out_ch.point_y    <= by_q;
			out_ch.tool_valid <= (r_q >= RATIO_W'(32768));
			if (r_q < RATIO_W'(32768) || raw[15])
				out_ch.tool_pos <= '0;
			else if (raw[14:12] != 3'd0)
				out_ch.tool_pos <= TPOS_W'(4095);
			else
				out_ch.tool_pos <= raw[TPOS_W-1:0];
			out_ch.last_point <= (step_q == n_q);
		end
	end

endmodule

FILE: rtl/bezier_scoop_trajectory_core.sv
// Top level of the Bezier scoop trajectory core.
// Depends on bst_pkg, bst_ifs, bst_regs, bst_mul (inside bst_seq) and bst_seq.
//
// Usage: a base point enters on in_ch (valid/ready transaction). For it the
// core emits N+1 curve points on out_ch, N being step_count (0 acts as 1),
// with last_point set on the final one. The core takes no new base point
// until the final point of the current curve has been taken.
// Sequence: a divider first forms 65536 / N, then for each point seven
// products go through the one shared multiplier (states M1 to M7), the
// result is formed in FIN and the point waits in the output register in EMIT.
// When the receiver holds ready low the point waits in the output register
// and the sequencer stops until the transaction completes.
// Configuration is written over the APB-style port while the core is idle;
// pready is always high. Reset returns the registers to their defaults and
// the sequencer to idle; there is no clearing pass.
module bezier_scoop_trajectory_core (
	input  logic                       clk,
	input  logic                       arst_n,
	bst_in_if.sink                     in_ch,
	bst_out_if.source                  out_ch,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bst_pkg::APB_AW-1:0] paddr,
	input  logic [bst_pkg::APB_DW-1:0] pwdata,
	output logic [bst_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import bst_pkg::*;

	bst_cfg_t cfg;

	bst_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	bst_seq u_seq (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .in_ch(in_ch), .out_ch(out_ch)
	);

endmodule

FILE: tb/bezier_scoop_trajectory_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for bezier_scoop_trajectory_core.
// Depends on bst_pkg and the bst_in_if / bst_out_if channel interfaces.
module bezier_scoop_trajectory_core_test;
	import bst_pkg::*;

	typedef struct {
		logic signed [COORD_W-1:0] base_x;
		logic signed [COORD_W-1:0] base_y;
		logic signed [COORD_W-1:0] base_z;
	} base_point_t;

	typedef struct {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
		logic                      tool_valid;
		logic [TPOS_W-1:0]         tool_pos;
		logic                      last_point;
	} curve_point_t;

	localparam longint COORD_MAX = (64'sd1 <<< (COORD_W - 1)) - 1;
	localparam longint COORD_MIN = -COORD_MAX - 1;
	localparam int     CYCLE_LIMIT = 3000000;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	bst_in_if  in_ch();
	bst_out_if out_ch();

	bezier_scoop_trajectory_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch.sink),
		.out_ch  (out_ch.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow copy of the configuration registers.
	int unsigned cfg_steps;
	int          cfg_scoop;
	int          cfg_center;
	int unsigned cfg_depth;
	int unsigned cfg_reach;

	base_point_t  pending_bases[$];
	curve_point_t expected_points[$];
	int           fail_count;
	int           cycle_count;
	int           stall_mode;
	int           burst_mode;
	int           hold_requests;

	// Clock generation.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Computes every curve point that one base point causes.
	function automatic void predict_curve_points(base_point_t b);
		int unsigned  n;
		longint unsigned r, u, w1, w2, w3, offx, offz;
		longint       v, rr, diff, prod, q, raw;
		curve_point_t p;
		n = (cfg_steps == 0) ? 1 : cfg_steps;
		if (n > MAX_STEPS)
			n = MAX_STEPS;
		for (int s = 0; s <= n; s++) begin
			r = (longint'(s) << 16) / n;
			u = 65536 - r;
			w1 = 3 * u * u * r;
			w2 = 3 * u * r * r;
			w3 = r * r * r;
			offx = (longint'(cfg_reach) * (w2 + w3) + (64'd1 << 47)) >> 48;
			offz = (longint'(cfg_depth) * (w1 + w2) + (64'd1 << 47)) >> 48;
			v = longint'(b.base_x) + longint'(offx);
			if (v > COORD_MAX) v = COORD_MAX;
			if (v < COORD_MIN) v = COORD_MIN;
			p.point_x = v[COORD_W-1:0];
			p.point_y = b.base_y;
			v = longint'(b.base_z) - longint'(offz);
			if (v > COORD_MAX) v = COORD_MAX;
			if (v < COORD_MIN) v = COORD_MIN;
			p.point_z = v[COORD_W-1:0];
			if (r >= 32768) begin
				rr = longint'((r - 32768) * 2);
				diff = longint'(cfg_center) - longint'(cfg_scoop);
				prod = diff * rr;
				q = (prod >= 0) ? (prod >>> 16) : -((-prod) >>> 16);
				raw = longint'(cfg_scoop) + q;
				if (raw < 0) raw = 0;
				if (raw > 4095) raw = 4095;
				p.tool_valid = 1'b1;
				p.tool_pos = raw[TPOS_W-1:0];
			end else begin
				p.tool_valid = 1'b0;
				p.tool_pos = '0;
			end
			p.last_point = (s == n);
			expected_points.push_back(p);
		end
	endfunction

	// Writes one register over the configuration port and updates the shadow copy.
	task automatic write_register(input logic [2:0] index, input logic [APB_DW-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'(index) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (index)
			REG_STEP_COUNT:  cfg_steps = value[STEP_W-1:0];
			REG_TOOL_SCOOP:  cfg_scoop = $signed(value[TOOL_W-1:0]);
			REG_TOOL_CENTER: cfg_center = $signed(value[TOOL_W-1:0]);
			REG_CURVE_DEPTH: cfg_depth = value[GEOM_W-1:0];
			REG_CURVE_REACH: cfg_reach = value[GEOM_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input int n, input int scoop, input int center,
		input int depth, input int reach);
		write_register(REG_STEP_COUNT, n);
		write_register(REG_TOOL_SCOOP, scoop);
		write_register(REG_TOOL_CENTER, center);
		write_register(REG_CURVE_DEPTH, depth);
		write_register(REG_CURVE_REACH, reach);
	endtask

	// Waits until the core has delivered everything that is owed.
	task automatic wait_drained();
		while (pending_bases.size() != 0 || expected_points.size() != 0 || in_ch.valid)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic queue_base(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
		input logic [COORD_W-1:0] z);
		base_point_t b;
		b.base_x = x;
		b.base_y = y;
		b.base_z = z;
		pending_bases.push_back(b);
	endtask

	function automatic logic [COORD_W-1:0] random_coord();
		case ($urandom_range(0, 5))
			0: random_coord = COORD_W'(COORD_MAX - $urandom_range(0, 70000));
			1: random_coord = COORD_W'(COORD_MIN + $urandom_range(0, 70000));
			2: random_coord = COORD_W'($urandom_range(0, 4000)) - COORD_W'(2000);
			default: random_coord = COORD_W'($urandom);
		endcase
	endfunction

	// Input driver: bursts of transactions, separated by random gaps when burst mode is on.
	int burst_left;
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.base_x <= '0;
			in_ch.base_y <= '0;
			in_ch.base_z <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				predict_curve_points(pending_bases.pop_front());
				if (burst_left > 0) begin
					burst_left <= burst_left - 1;
				end else if (burst_mode != 0) begin
					burst_left <= $urandom_range(0, 5);
					gap_left <= $urandom_range(1, 40);
				end
			end
			if (!(in_ch.valid && !in_ch.ready)) begin
				if (gap_left > 0 && !(in_ch.valid && in_ch.ready && burst_left == 0)) begin
					gap_left <= gap_left - 1;
					in_ch.valid <= 1'b0;
				end else if (in_ch.valid && in_ch.ready && burst_left == 0 && burst_mode != 0) begin
					in_ch.valid <= 1'b0;
				end else if (pending_bases.size() != 0) begin
					in_ch.valid <= 1'b1;
					in_ch.base_x <= pending_bases[0].base_x;
					in_ch.base_y <= pending_bases[0].base_y;
					in_ch.base_z <= pending_bases[0].base_z;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Output ready pattern, with an occasional long hold-off on request.
	int hold_left;
	int hold_seen;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_seen != hold_requests) begin
			hold_seen <= hold_requests;
			hold_left <= 1500;
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else begin
			case (stall_mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= ($urandom_range(0, 3) != 0);
				default: out_ch.ready <= ($urandom_range(0, 9) < 3);
			endcase
		end
	end

	// Monitor: compares each accepted curve point with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_points.size() == 0) begin
				$error("unexpected curve point x=%0d z=%0d", out_ch.point_x, out_ch.point_z);
				fail_count++;
			end else begin
				curve_point_t e;
				e = expected_points.pop_front();
				if (out_ch.point_x !== e.point_x) begin
					$error("point_x expected %0d actual %0d", e.point_x, out_ch.point_x);
					fail_count++;
				end
				if (out_ch.point_y !== e.point_y) begin
					$error("point_y expected %0d actual %0d", e.point_y, out_ch.point_y);
					fail_count++;
				end
				if (out_ch.point_z !== e.point_z) begin
					$error("point_z expected %0d actual %0d", e.point_z, out_ch.point_z);
					fail_count++;
				end
				if (out_ch.tool_valid !== e.tool_valid) begin
					$error("tool_valid expected %0d actual %0d", e.tool_valid, out_ch.tool_valid);
					fail_count++;
				end
				if (out_ch.tool_pos !== e.tool_pos) begin
					$error("tool_pos expected %0d actual %0d", e.tool_pos, out_ch.tool_pos);
					fail_count++;
				end
				if (out_ch.last_point !== e.last_point) begin
					$error("last_point expected %0d actual %0d", e.last_point, out_ch.last_point);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("bezier_scoop_trajectory_core_test failed");
			$finish;
		end
	end

	// Stimulus sequence: directed phases, then random configurations.
	initial begin
		cycle_count = 0;
		fail_count = 0;
		stall_mode = 0;
		burst_mode = 0;
		hold_requests = 0;
		cfg_steps = 32;
		cfg_scoop = 2048;
		cfg_center = 2048;
		cfg_depth = 12800;
		cfg_reach = 12800;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset defaults.
		queue_base(0, 0, 0);
		queue_base(24'sd1000, -24'sd500, 24'sd20000);
		wait_drained();

		// Single interval with the widest geometry and a full tool ramp.
		write_all(1, -8192, 8191, 65535, 65535);
		queue_base(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
		queue_base(24'h800000, 24'h800000, 24'h800000);
		queue_base(24'h7FFFF0, 24'h000000, 24'h800010);
		wait_drained();

		// Zero step count acts as one; reversed ramp; zero geometry.
		write_all(0, 8191, -8192, 0, 0);
		queue_base(24'h800000, 24'h7FFFFF, 24'h000001);
		queue_base(24'h7FFFFF, 24'h800000, 24'hFFFFFF);
		wait_drained();

		// Writes outside the register list leave the registers untouched.
		write_register(3'd5, 32'hFFFF_FFFF);
		write_register(3'd7, 32'h0000_0001);
		queue_base(24'sd12345, 24'sd6789, -24'sd4321);
		wait_drained();

		// Longest curve, with extra bits above the field width, and a long hold-off.
		write_all(32'hFFFF_FFFF, 4000, 100, 1000, 40000);
		stall_mode = 1;
		for (int i = 0; i < 6; i++)
			queue_base(random_coord(), random_coord(), random_coord());
		hold_requests = hold_requests + 1;
		wait_drained();

		// Random configurations, mostly short curves.
		for (int ph = 0; ph < 8; ph++) begin
			int n;
			n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 6);
			write_all(n, $urandom_range(0, 16383) - 8192, $urandom_range(0, 16383) - 8192,
				$urandom_range(0, 65535), $urandom_range(0, 65535));
			stall_mode = ph % 3;
			burst_mode = (ph % 4 != 0);
			for (int i = 0; i < 40; i++)
				queue_base(random_coord(), random_coord(), random_coord());
			if (ph == 5)
				hold_requests = hold_requests + 1;
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0 && expected_points.size() == 0) begin
			$display("bezier_scoop_trajectory_core_test passed");
		end else begin
			$display("bezier_scoop_trajectory_core_test failed");
		end
		$finish;
	end

endmodule
